### hdl/can_frame_mailbox_with_freshness_unit_assert.svh
// Assertion macros shared by the mailbox RTL.
`ifndef CAN_FRAME_MAILBOX_WITH_FRESHNESS_UNIT_ASSERT_SVH
`define CAN_FRAME_MAILBOX_WITH_FRESHNESS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while reset is low.
`define CFM_ASSERT_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mailbox assertion failed");
// Checked at every edge, also during reset.
`define CFM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mailbox assertion failed");
`else
`define CFM_ASSERT_RST(label, clk, rst, prop)
`define CFM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### hdl/cfm_pkg.sv
`timescale 1ns / 1ps

package cfm_pkg;

   localparam int SOURCE_SLOTS = 16;
   localparam int TABLE_SIZE   = 16;
   localparam int SLOT_W       = 4;
   localparam int ID_W         = 29;
   localparam int DATA_W       = 64;
   localparam int TIME_W       = 32;
   localparam int MASK_W       = 16;
   localparam int CSR_IDX_W    = 8;
   localparam int CSR_DATA_W   = 32;

   localparam logic [TIME_W-1:0]  FRESH_LIMIT_RESET = 32'd500;
   localparam logic [MASK_W-1:0]  STATUS_MASK_RESET = 16'hFFFF;
   localparam logic [3:0]         FRAME_DLC         = 4'd8;
   localparam logic [SLOT_W-1:0]  STATUS_SLOT       = 4'd3;

   localparam logic               ACTION_FRAME      = 1'b0;
   localparam logic               ACTION_QUERY      = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FRESH_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATUS_MASK = 8'd1;

   typedef logic [ID_W-1:0] source_id_type;

   localparam source_id_type SOURCE_IDS [TABLE_SIZE] = '{
      29'h520, 29'h521, 29'h522, 29'h526, 29'h527, 29'h530, 29'h536, 29'h538,
      29'h600, 29'h601, 29'h602, 29'h610, 29'h611, 29'h612, 29'h620, 29'h621
   };

endpackage

### hdl/cfm_ram.sv
`timescale 1ns / 1ps

module cfm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/can_frame_mailbox_with_freshness_unit.sv
`timescale 1ns / 1ps
// CAN mailbox with per-source freshness.
// The req_ channel carries one word per received CAN frame (req_action = 0)
// or per slot query (req_action = 1). A standard data frame with DLC 8 whose
// identifier is one of the sixteen source identifiers is stored in its slot.
// Every word yields exactly one rsp_ word: the accept flag, the slot, the
// queried payload (slot 3 has its low 16 bits masked by status_bit_mask), the
// fresh mask computed with the word's own now_ms, and the global receive info.
// The csr_ channel writes fresh_limit_ms (index 0) and status_bit_mask
// (index 1); other indexes are ignored. csr_ready is always high.
// An accepted word is held in the item registers while in S_RESP and moves
// into the output register, which drives rsp_valid, once that register is free.
// No new word is taken while one is in S_RESP, as req_ready is low there; the
// payload memory read is registered, and the sixteen freshness comparators run in parallel.
// If rsp_ready is low, the finished word waits in the output register; one
// more request may be taken and then waits for the output to drain.
// Reset clears all received bits, the seen flag and the last-receive time and
// restores the register defaults; payload and timestamp stores need no clearing.
`include "can_frame_mailbox_with_freshness_unit_assert.svh"

module can_frame_mailbox_with_freshness_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [cfm_pkg::ID_W-1:0]        req_frame_id,
   input  logic                            req_is_extended,
   input  logic                            req_is_remote,
   input  logic [3:0]                      req_frame_length,
   input  logic [cfm_pkg::DATA_W-1:0]      req_payload,
   input  logic [cfm_pkg::TIME_W-1:0]      req_now_ms,
   input  logic [cfm_pkg::SLOT_W-1:0]      req_query_slot,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_accepted,
   output logic [cfm_pkg::SLOT_W-1:0]      rsp_matched_slot,
   output logic [cfm_pkg::DATA_W-1:0]      rsp_slot_payload,
   output logic                            rsp_slot_received,
   output logic [cfm_pkg::MASK_W-1:0]      rsp_fresh_sources,
   output logic                            rsp_any_frame_seen,
   output logic [cfm_pkg::TIME_W-1:0]      rsp_last_frame_ms,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cfm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cfm_pkg::CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic {S_IDLE, S_RESP} state_type;

   state_type                       state_ff;
   logic [cfm_pkg::TIME_W-1:0]      fresh_limit_ff;
   logic [cfm_pkg::MASK_W-1:0]      status_mask_ff;
   logic [cfm_pkg::TABLE_SIZE-1:0]  received_ff;
   logic [cfm_pkg::TIME_W-1:0]      slot_time_ff [cfm_pkg::TABLE_SIZE];
   logic                            seen_any_ff;
   logic [cfm_pkg::TIME_W-1:0]      latest_ff;

   // Item held between accept and response.
   logic                            item_query_ff;
   logic                            item_hit_ff;
   logic [cfm_pkg::SLOT_W-1:0]      item_slot_ff;
   logic [cfm_pkg::TIME_W-1:0]      item_now_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_accepted_ff;
   logic [cfm_pkg::SLOT_W-1:0]      rsp_slot_ff;
   logic [cfm_pkg::DATA_W-1:0]      rsp_payload_ff;
   logic                            rsp_received_ff;
   logic [cfm_pkg::MASK_W-1:0]      rsp_fresh_ff;
   logic                            rsp_seen_ff;
   logic [cfm_pkg::TIME_W-1:0]      rsp_latest_ff;

   logic                            req_fire;
   logic                            id_hit;
   logic [cfm_pkg::SLOT_W-1:0]      id_slot;
   logic                            frame_ok;
   logic                            store_en;
   logic                            rsp_free;
   logic [cfm_pkg::DATA_W-1:0]      ram_rd_data;
   logic [cfm_pkg::DATA_W-1:0]      pay_in;
   logic                            rcv_in;
   logic [cfm_pkg::MASK_W-1:0]      fresh_in;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Identifier lookup; the loop runs downward so the lowest slot wins.
   always_comb begin
      id_hit  = 1'b0;
      id_slot = '0;
      for (int i = cfm_pkg::SOURCE_SLOTS - 1; i >= 0; i--) begin
         if (req_frame_id == cfm_pkg::SOURCE_IDS[i]) begin
            id_hit  = 1'b1;
            id_slot = cfm_pkg::SLOT_W'(i);
         end
      end
   end

   assign frame_ok = !req_is_extended && !req_is_remote &&
                     (req_frame_length == cfm_pkg::FRAME_DLC) && id_hit;
   assign store_en = req_fire && (req_action == cfm_pkg::ACTION_FRAME) && frame_ok;

   cfm_ram #(
      .WIDTH (cfm_pkg::DATA_W),
      .DEPTH (cfm_pkg::TABLE_SIZE)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (id_slot),
      .wr_data (req_payload),
      .rd_en   (req_fire && (req_action == cfm_pkg::ACTION_QUERY)),
      .rd_addr (req_query_slot),
      .rd_data (ram_rd_data)
   );

   // One comparator per slot on the wrapped age.
   always_comb begin
      fresh_in = '0;
      for (int i = 0; i < cfm_pkg::TABLE_SIZE; i++) begin
         fresh_in[i] = received_ff[i] &&
                       ((item_now_ff - slot_time_ff[i]) <= fresh_limit_ff);
      end
   end

   always_comb begin
      rcv_in = item_query_ff && received_ff[item_slot_ff];
      pay_in = '0;
      if (rcv_in) begin
         pay_in = ram_rd_data;
         if (item_slot_ff == cfm_pkg::STATUS_SLOT) begin
            pay_in[cfm_pkg::MASK_W-1:0] = ram_rd_data[cfm_pkg::MASK_W-1:0] & status_mask_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         fresh_limit_ff <= cfm_pkg::FRESH_LIMIT_RESET;
         status_mask_ff <= cfm_pkg::STATUS_MASK_RESET;
         received_ff    <= '0;
         seen_any_ff    <= 1'b0;
         latest_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               cfm_pkg::CSR_FRESH_LIMIT: fresh_limit_ff <= csr_data;
               cfm_pkg::CSR_STATUS_MASK: status_mask_ff <= csr_data[cfm_pkg::MASK_W-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready && (state_ff == S_IDLE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  item_query_ff <= (req_action == cfm_pkg::ACTION_QUERY);
                  item_hit_ff   <= store_en;
                  item_slot_ff  <= (req_action == cfm_pkg::ACTION_QUERY) ? req_query_slot
                                 : (frame_ok ? id_slot : '0);
                  item_now_ff   <= req_now_ms;
                  if (store_en) begin
                     slot_time_ff[id_slot] <= req_now_ms;
                     received_ff[id_slot]  <= 1'b1;
                     seen_any_ff           <= 1'b1;
                     latest_ff             <= req_now_ms;
                  end
                  state_ff <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= item_hit_ff;
                  rsp_slot_ff     <= item_slot_ff;
                  rsp_payload_ff  <= pay_in;
                  rsp_received_ff <= rcv_in;
                  rsp_fresh_ff    <= fresh_in;
                  rsp_seen_ff     <= seen_any_ff;
                  rsp_latest_ff   <= latest_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_matched_slot   = rsp_slot_ff;
   assign rsp_slot_payload   = rsp_payload_ff;
   assign rsp_slot_received  = rsp_received_ff;
   assign rsp_fresh_sources  = rsp_fresh_ff;
   assign rsp_any_frame_seen = rsp_seen_ff;
   assign rsp_last_frame_ms  = rsp_latest_ff;

   `CFM_ASSERT_RST(a_store_updates_latest, clock, reset,
      store_en |=> seen_any_ff && (latest_ff == $past(req_now_ms)))
   `CFM_ASSERT_RST(a_accepted_is_fresh, clock, reset,
      (rsp_valid_ff && rsp_accepted_ff) |-> rsp_fresh_ff[rsp_slot_ff] && rsp_seen_ff)
   `CFM_ASSERT_RST(a_received_bit_backs_reply, clock, reset,
      (rsp_valid_ff && rsp_received_ff) |-> received_ff[rsp_slot_ff])
   `CFM_ASSERT_RST(a_fresh_only_received, clock, reset,
      (rsp_fresh_ff & ~received_ff) == '0 || !rsp_valid_ff)

endmodule
